@@ hw/rtl/multi_protocol_rf_remote_encoder_core_assert.svh @@
// Assertion macros shared by the encoder core.
`ifndef MULTI_PROTOCOL_RF_REMOTE_ENCODER_CORE_ASSERT_SVH
`define MULTI_PROTOCOL_RF_REMOTE_ENCODER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MPRE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("encoder core assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MPRE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("encoder core assertion failed");

`endif

@@ hw/rtl/mpre_pkg.sv @@
package mpre_pkg;

    localparam logic [1:0] MODE_ROLL = 2'd0;
    localparam logic [1:0] MODE_S57  = 2'd1;
    localparam logic [1:0] MODE_TRI  = 2'd2;
    localparam logic [1:0] MODE_ALL  = 2'd3;

    localparam logic [11:0] ROLL_TAB [16] = '{
        12'h609, 12'h306, 12'h803, 12'ha08, 12'h00a, 12'h200, 12'hc02, 12'h40c,
        12'he04, 12'h70e, 12'h507, 12'h105, 12'hf01, 12'hb0f, 12'hd0b, 12'h90d
    };

    localparam logic [4:0] SYM_TAB [16] = '{
        5'h07, 5'h0b, 5'h0d, 5'h0e, 5'h13, 5'h15, 5'h16, 5'h19,
        5'h1a, 5'h1c, 5'h03, 5'h05, 5'h06, 5'h09, 5'h0a, 5'h0c
    };

    localparam int TRI_DIGITS = 8;
    localparam int TRI_LOG2 [TRI_DIGITS] = '{2, 4, 5, 7, 8, 10, 12, 13};
    localparam int TRI_DIV  [TRI_DIGITS] = '{3, 9, 27, 81, 243, 729, 2187, 6561};

    typedef struct packed {
        logic [3:0] payload_bytes;
        logic [5:0] bit_count;
        logic [4:0] repeat_count;
        logic [9:0] start_high_ticks;
        logic [9:0] start_low_ticks;
        logic [7:0] zero_high_ticks;
        logic [7:0] zero_low_ticks;
        logic [7:0] one_high_ticks;
        logic [7:0] one_low_ticks;
    } t_timing;

    typedef struct packed {
        logic [1:0]  protocol;
        logic [63:0] payload;
        t_timing     timing;
        logic        last;
    } t_result;

    function automatic t_timing timing_for(input logic [1:0] proto);
        t_timing t;
        unique case (proto)
            MODE_ROLL: t = '{4'd4, 6'd28, 5'd7, 10'd32, 10'd480,
                             8'd32, 8'd96, 8'd96, 8'd32};
            MODE_S57:  t = '{4'd8, 6'd57, 5'd7, 10'd26, 10'd860,
                             8'd26, 8'd26, 8'd26, 8'd130};
            MODE_TRI:  t = '{4'd3, 6'd24, 5'd18, 10'd32, 10'd970,
                             8'd32, 8'd96, 8'd96, 8'd32};
            default:   t = '0;
        endcase
        return t;
    endfunction

endpackage

@@ hw/rtl/mpre_rolling_enc.sv @@
module mpre_rolling_enc (
    input  logic [1:0]  i_counter,
    input  logic [15:0] i_device_code,
    input  logic [7:0]  i_command,
    output logic [63:0] o_payload
);

    logic [3:0]  g [7];
    logic [3:0]  k [6];
    logic [3:0]  c [6];
    logic [3:0]  dim;
    logic [3:0]  c_dim;
    logic [7:0]  cmd_m1;
    logic [27:0] word;

    always_comb begin
        cmd_m1 = i_command - 8'd1;
        dim    = ((i_command != 8'd0) && (i_command < 8'd9)) ? {1'b1, cmd_m1[2:0]} : 4'd0;
        g[0] = 4'd1;
        g[1] = {i_counter, (i_command != 8'd0), 1'b0};
        g[2] = i_device_code[3:0];
        g[3] = i_device_code[7:4];
        g[4] = i_device_code[11:8];
        g[5] = i_device_code[15:12];
        g[6] = dim;
        k[0] = mpre_pkg::ROLL_TAB[g[0]][11:8];
        for (int i = 1; i < 6; i++) begin
            k[i] = mpre_pkg::ROLL_TAB[g[i] ^ k[i-1]][11:8];
        end
        c[0] = mpre_pkg::ROLL_TAB[k[0]][3:0];
        for (int i = 1; i < 6; i++) begin
            c[i] = mpre_pkg::ROLL_TAB[k[i] ^ c[i-1]][3:0];
        end
        c_dim = g[6] ^ 4'd9;
        word  = {c_dim, c[5], c[4], c[3], c[2], c[1], c[0]};
        o_payload = {word[1:0], word[27:2], 36'd0};
    end

endmodule

@@ hw/rtl/mpre_sym57_enc.sv @@
module mpre_sym57_enc (
    input  logic [15:0] i_device_code,
    input  logic [7:0]  i_command,
    output logic [63:0] o_payload
);

    logic [3:0] nib [8];
    logic [6:0] sym [8];

    always_comb begin
        nib[0] = 4'd0;
        nib[1] = 4'd0;
        nib[2] = i_device_code[15:12];
        nib[3] = i_device_code[11:8];
        nib[4] = i_device_code[7:4];
        nib[5] = i_device_code[3:0];
        nib[6] = {3'd0, (i_command != 8'd0)};
        nib[7] = 4'd0;
        for (int i = 0; i < 8; i++) begin
            sym[i] = {2'b10, mpre_pkg::SYM_TAB[nib[i]]};
        end
        o_payload = {1'b1, sym[0], sym[1], sym[2], sym[3], sym[4], sym[5], sym[6],
                     sym[7], 7'd0};
    end

endmodule

@@ hw/rtl/mpre_trinary_enc.sv @@
module mpre_trinary_enc (
    input  logic [15:0] i_device_code,
    input  logic [7:0]  i_command,
    output logic [63:0] o_payload
);

    logic [15:0] quot [mpre_pkg::TRI_DIGITS + 1];

    assign quot[0] = i_device_code;

    // Each power-of-three quotient is a reciprocal multiply, all independent.
    for (genvar g = 0; g < mpre_pkg::TRI_DIGITS; g++) begin : g_quot
        localparam int unsigned Mul =
            (32'd1 << (16 + mpre_pkg::TRI_LOG2[g])) / mpre_pkg::TRI_DIV[g] + 1;
        localparam logic [16:0] MulV = 17'(Mul);
        logic [32:0] prod;
        logic [32:0] shifted;
        always_comb begin
            prod       = 33'(i_device_code) * 33'(MulV);
            shifted    = prod >> (16 + mpre_pkg::TRI_LOG2[g]);
            quot[g+1]  = shifted[15:0];
        end
    end

    logic [17:0] diff [mpre_pkg::TRI_DIGITS];
    logic [15:0] addr;
    logic [7:0]  status;

    always_comb begin
        for (int i = 0; i < mpre_pkg::TRI_DIGITS; i++) begin
            diff[i] = {2'b00, quot[i]} - ({2'b00, quot[i+1]} + {1'b0, quot[i+1], 1'b0});
            unique case (diff[i][1:0])
                2'd1:    addr[2*i +: 2] = 2'd3;
                2'd2:    addr[2*i +: 2] = 2'd1;
                default: addr[2*i +: 2] = 2'd0;
            endcase
        end
        status    = {7'b0001010, (i_command != 8'd0)};
        o_payload = {addr, status, 40'd0};
    end

endmodule

@@ hw/rtl/multi_protocol_rf_remote_encoder_core.sv @@
// Remote-switch code encoder core.
// Input channel: i_in_valid / o_in_stall carry one beat of mode, device code
// and command. Output channel: o_out_valid / i_out_stall carry one beat per
// result with the protocol number, the left-aligned payload, the bit, byte
// and frame counts, the pulse timing words and a last flag.
// Modes 0, 1 and 2 give one result beat; mode 3 gives three beats in the
// order rolling, 57-bit, trinary, with last set on the third.
// From input beat to the first result beat the path runs through one input
// register, one encode pass and one result register.
// While the receiver does not stall, the core takes one input beat per cycle
// for single-protocol modes, and a mode 3 item holds the input register until
// its trinary beat is issued; the result register emits one beat per cycle.
// Reset clears the rolling counter, the step and the input and result valid
// flags. While the receiver stalls, the result beat holds, and the input
// register takes no new beat once it holds an unfinished item.
`include "multi_protocol_rf_remote_encoder_core_assert.svh"

module multi_protocol_rf_remote_encoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_device_code,
    input  logic [7:0]  i_command,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_protocol,
    output logic [63:0] o_payload,
    output logic [3:0]  o_payload_bytes,
    output logic [5:0]  o_bit_count,
    output logic [4:0]  o_repeat_count,
    output logic [9:0]  o_start_high_ticks,
    output logic [9:0]  o_start_low_ticks,
    output logic [7:0]  o_zero_high_ticks,
    output logic [7:0]  o_zero_low_ticks,
    output logic [7:0]  o_one_high_ticks,
    output logic [7:0]  o_one_low_ticks,
    output logic        o_last
);

    logic                r_valid;
    logic [1:0]          r_mode;
    logic [15:0]         r_dev;
    logic [7:0]          r_cmd;
    logic [1:0]          r_step;
    logic [1:0]          r_counter;
    logic                r_out_valid;
    mpre_pkg::t_result   r_out;

    logic                out_free;
    logic                fire;
    logic                roll_fire;
    logic                sel_last;
    logic                in_take;
    logic [1:0]          sel;
    logic [1:0]          n_counter;
    logic [63:0]         pay_roll;
    logic [63:0]         pay_s57;
    logic [63:0]         pay_tri;
    mpre_pkg::t_result   n_out;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_valid && out_free;
    assign sel        = (r_mode == mpre_pkg::MODE_ALL) ? r_step : r_mode;
    assign roll_fire  = fire && (sel == mpre_pkg::MODE_ROLL);
    assign sel_last   = (r_mode != mpre_pkg::MODE_ALL) || (r_step == mpre_pkg::MODE_TRI);
    assign in_take    = !r_valid || (fire && sel_last);
    assign o_in_stall = !in_take;
    assign n_counter  = r_counter + 2'd1;

    mpre_rolling_enc u_roll (
        .i_counter     (n_counter),
        .i_device_code (r_dev),
        .i_command     (r_cmd),
        .o_payload     (pay_roll)
    );

    mpre_sym57_enc u_s57 (
        .i_device_code (r_dev),
        .i_command     (r_cmd),
        .o_payload     (pay_s57)
    );

    mpre_trinary_enc u_tri (
        .i_device_code (r_dev),
        .i_command     (r_cmd),
        .o_payload     (pay_tri)
    );

    always_comb begin
        n_out.protocol = sel;
        n_out.timing   = mpre_pkg::timing_for(sel);
        n_out.last     = sel_last;
        unique case (sel)
            mpre_pkg::MODE_ROLL: n_out.payload = pay_roll;
            mpre_pkg::MODE_S57:  n_out.payload = pay_s57;
            mpre_pkg::MODE_TRI:  n_out.payload = pay_tri;
            default:             n_out.payload = 64'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_step      <= 2'd0;
            r_counter   <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_valid <= i_in_valid;
                r_step  <= 2'd0;
            end else if (fire) begin
                r_step <= r_step + 2'd1;
            end
            if (roll_fire) begin
                r_counter <= n_counter;
            end
            if (out_free) begin
                r_out_valid <= fire;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take && i_in_valid) begin
            r_mode <= i_mode;
            r_dev  <= i_device_code;
            r_cmd  <= i_command;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_protocol         = r_out.protocol;
    assign o_payload          = r_out.payload;
    assign o_payload_bytes    = r_out.timing.payload_bytes;
    assign o_bit_count        = r_out.timing.bit_count;
    assign o_repeat_count     = r_out.timing.repeat_count;
    assign o_start_high_ticks = r_out.timing.start_high_ticks;
    assign o_start_low_ticks  = r_out.timing.start_low_ticks;
    assign o_zero_high_ticks  = r_out.timing.zero_high_ticks;
    assign o_zero_low_ticks   = r_out.timing.zero_low_ticks;
    assign o_one_high_ticks   = r_out.timing.one_high_ticks;
    assign o_one_low_ticks    = r_out.timing.one_low_ticks;
    assign o_last             = r_out.last;

    `MPRE_ASSERT_NOW(a_proto_valid, i_clk, i_rst_n, o_out_valid, o_protocol != mpre_pkg::MODE_ALL)
    `MPRE_ASSERT_NOW(a_step_range, i_clk, i_rst_n, r_valid, r_step != 2'd3)
    `MPRE_ASSERT_NEXT(a_counter_step, i_clk, i_rst_n, roll_fire, r_counter == $past(r_counter) + 2'd1)
    `MPRE_ASSERT_NOW(a_hold_item, i_clk, i_rst_n, r_valid && !(fire && sel_last), o_in_stall)

endmodule
